// File: design/ntbl_pkg.sv
// Shared constants, types and arithmetic helpers for the nearest-three lookup.
`default_nettype none

package ntbl_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int FIELD_W         = 32;
    localparam int INDEX_W         = 6;
    localparam int CFG_W           = 7;
    localparam int WEIGHT_BITS     = 30;
    localparam int WEIGHT_W        = WEIGHT_BITS + 1;
    localparam int OPND_W          = 35;
    localparam int PROD_W          = 2 * OPND_W;
    localparam int DIST_W          = 68;
    localparam int MIN_ENTRIES     = 3;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_MX     = 10'b00_0000_0010,
        S_MY     = 10'b00_0000_0100,
        S_INS    = 10'b00_0000_1000,
        S_FETCH  = 10'b00_0001_0000,
        S_CROSS  = 10'b00_0010_0000,
        S_DECIDE = 10'b00_0100_0000,
        S_DIV    = 10'b00_1000_0000,
        S_BLEND  = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } state_t;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    function automatic logic signed [FIELD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [FIELD_W-1:0] r;
        if (v > 70'sh7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -70'sh8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[FIELD_W-1:0];
        return r;
    endfunction

    function automatic logic [PROD_W-1:0] mag70(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] r;
        r = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: design/ntbl_in_if.sv
// Input channel: load and query transactions.
`default_nettype none

interface ntbl_in_if
    import ntbl_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [INDEX_W-1:0]         entry_index;
    logic signed [FIELD_W-1:0]  design_width;
    logic signed [FIELD_W-1:0]  design_height;
    logic signed [FIELD_W-1:0]  measured_width;
    logic signed [FIELD_W-1:0]  measured_height;
    logic signed [FIELD_W-1:0]  query_half_width;
    logic signed [FIELD_W-1:0]  query_half_height;

    modport source (
        output valid, func, entry_index, design_width, design_height,
               measured_width, measured_height, query_half_width, query_half_height,
        input  ready
    );
    modport sink (
        input  valid, func, entry_index, design_width, design_height,
               measured_width, measured_height, query_half_width, query_half_height,
        output ready
    );
endinterface

`default_nettype wire

// File: design/ntbl_out_if.sv
// Output channel: corrected size transactions.
`default_nettype none

interface ntbl_out_if
    import ntbl_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [FIELD_W-1:0]  corrected_half_width;
    logic signed [FIELD_W-1:0]  corrected_half_height;
    logic                       extrapolated;
    logic [INDEX_W-1:0]         nearest_entry;

    modport source (
        output valid, corrected_half_width, corrected_half_height, extrapolated,
               nearest_entry,
        input  ready
    );
    modport sink (
        input  valid, corrected_half_width, corrected_half_height, extrapolated,
               nearest_entry,
        output ready
    );
endinterface

`default_nettype wire

// File: design/ntbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ntbl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

// File: design/nearest_three_barycentric_lookup.sv
// Top level of the nearest-three barycentric size lookup.
//
//  channel  | dir | handshake     | carries
//  ---------+-----+---------------+-----------------------------------------
//  req      | in  | valid/ready   | func, entry_index, sizes, query halves
//  rsp      | out | valid/ready   | corrected halves, extrapolated, nearest
//  cfg      | in  | cfg_we        | entries_in_use (7 bits)
//
// A load is written in S_IDLE. A query scans each searched entry through
// S_MX, S_MY and S_INS (one shared 35x35 multiplier squares dx then dy),
// then S_FETCH, S_CROSS and S_DECIDE; when interpolating, S_DIV (one quotient
// bit a cycle, three weights) and S_BLEND follow, and S_DONE hands over.
// req.ready is high only between queries; a finished result waits in the
// rsp register while the next transaction is taken. rst_n clears control only.
`default_nettype none

module nearest_three_barycentric_lookup
    import ntbl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    ntbl_in_if.sink               req,
    ntbl_out_if.source            rsp,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata
);
    localparam int AW = $clog2(TABLE_DEPTH);

    state_t                     state_reg;
    logic [CFG_W-1:0]           entries_reg;
    logic [AW-1:0]              idx_reg;
    logic [AW-1:0]              last_idx;
    logic [4:0]                 step_reg;
    logic [1:0]                 wsel_reg;

    logic signed [FIELD_W:0]    tx_reg, ty_reg;
    logic signed [PROD_W-1:0]   mul_reg, acc_reg;
    logic [DIST_W-1:0]          bd_reg [3];
    logic [AW-1:0]              bi_reg [3];
    logic [2:0]                 v_reg;
    logic signed [FIELD_W-1:0]  mx_reg [3], my_reg [3], dw_reg [3], dh_reg [3];
    logic signed [PROD_W-1:0]   cr_reg [4];
    logic [PROD_W-1:0]          r_reg;
    logic [WEIGHT_W-1:0]        q_reg;
    logic [WEIGHT_W-1:0]        w_reg [3];
    logic signed [PROD_W-1:0]   accw_reg, acch_reg;
    logic signed [FIELD_W-1:0]  resw_reg, resh_reg;
    logic                       extra_reg;

    logic                       out_valid_reg;
    logic signed [FIELD_W-1:0]  outw_reg, outh_reg;
    logic                       outx_reg;
    logic [INDEX_W-1:0]         outn_reg;

    // table memories
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [2*FIELD_W-1:0]       mrd, drd;

    logic                       accept;
    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign ram_we    = accept && (req.func == FUNC_LOAD)
                       && (32'(req.entry_index) < TABLE_DEPTH);
    assign ram_waddr = AW'(req.entry_index);

    ntbl_ram #(.WIDTH(2*FIELD_W), .DEPTH(TABLE_DEPTH)) u_measured (
        .clk(clk), .we(ram_we), .waddr(ram_waddr),
        .wdata({req.measured_height, req.measured_width}),
        .raddr(ram_raddr), .rdata(mrd)
    );
    ntbl_ram #(.WIDTH(2*FIELD_W), .DEPTH(TABLE_DEPTH)) u_design (
        .clk(clk), .we(ram_we), .waddr(ram_waddr),
        .wdata({req.design_height, req.design_width}),
        .raddr(ram_raddr), .rdata(drd)
    );

    // clamp the searched count to 3..TABLE_DEPTH
    always_comb
    begin
        if (32'(entries_reg) > TABLE_DEPTH)
            last_idx = AW'(TABLE_DEPTH - 1);
        else if (32'(entries_reg) < MIN_ENTRIES)
            last_idx = AW'(MIN_ENTRIES - 1);
        else
            last_idx = AW'(entries_reg - 7'd1);
    end

    always_comb
    begin
        case (state_reg)
            S_INS:   ram_raddr = idx_reg + 1'b1;
            S_FETCH:
            begin
                if (step_reg[1:0] == 2'd0)
                    ram_raddr = bi_reg[0];
                else if (step_reg[1:0] == 2'd1)
                    ram_raddr = bi_reg[1];
                else
                    ram_raddr = bi_reg[2];
            end
            S_IDLE:  ram_raddr = '0;
            default: ram_raddr = idx_reg;
        endcase
    end

    // scan distance terms
    logic signed [FIELD_W+1:0] sdx, sdy;
    assign sdx = 34'(tx_reg) - 34'(signed'(mrd[FIELD_W-1:0]));
    assign sdy = 34'(ty_reg) - 34'(signed'(mrd[2*FIELD_W-1:FIELD_W]));

    // cross-product operands: points 0 = target, 1..3 = nearest three
    logic signed [FIELD_W:0]   ptx [4], pty [4];
    logic [1:0]                pp, pq, pr;
    logic signed [FIELD_W+1:0] ca, cb;
    always_comb
    begin
        ptx[0] = tx_reg;
        pty[0] = ty_reg;
        for (int i = 0; i < 3; i++)
        begin
            ptx[i+1] = 33'(mx_reg[i]);
            pty[i+1] = 33'(my_reg[i]);
        end
        case (step_reg[2:1])
            2'd0:    begin pp = 2'd1; pq = 2'd2; pr = 2'd3; end
            2'd1:    begin pp = 2'd0; pq = 2'd2; pr = 2'd3; end
            2'd2:    begin pp = 2'd0; pq = 2'd3; pr = 2'd1; end
            default: begin pp = 2'd0; pq = 2'd1; pr = 2'd2; end
        endcase
        if (!step_reg[0])
        begin
            ca = 34'(ptx[pq]) - 34'(ptx[pp]);
            cb = 34'(pty[pr]) - 34'(pty[pp]);
        end
        else
        begin
            ca = 34'(pty[pq]) - 34'(pty[pp]);
            cb = 34'(ptx[pr]) - 34'(ptx[pp]);
        end
    end

    // blend operands
    logic [1:0]                bslot;
    logic signed [FIELD_W-1:0] bdes;
    logic [WEIGHT_W-1:0]       bw;
    always_comb
    begin
        bslot = step_reg[2:1];
        case (bslot)
            2'd0:    begin bw = w_reg[0]; bdes = step_reg[0] ? dh_reg[0] : dw_reg[0]; end
            2'd1:    begin bw = w_reg[1]; bdes = step_reg[0] ? dh_reg[1] : dw_reg[1]; end
            default: begin bw = w_reg[2]; bdes = step_reg[0] ? dh_reg[2] : dw_reg[2]; end
        endcase
    end

    // shared multiplier operand select
    logic signed [OPND_W-1:0] mul_a, mul_b;
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MX:
            begin
                mul_a = 35'(sdx);
                mul_b = 35'(sdx);
            end
            S_MY:
            begin
                mul_a = 35'(sdy);
                mul_b = 35'(sdy);
            end
            S_CROSS:
            begin
                mul_a = 35'(ca);
                mul_b = 35'(cb);
            end
            S_BLEND:
            begin
                mul_a = 35'(bdes);
                mul_b = signed'({4'b0000, bw});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // top-three insertion, ties keep the earlier entry ahead
    logic [DIST_W-1:0] cand_dist;
    logic [2:0]        lt;
    assign cand_dist = DIST_W'(acc_reg + mul_reg);
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            lt[j] = !v_reg[j] || (cand_dist < bd_reg[j]);
        end
    end

    // decision
    logic [PROD_W-1:0]           den;
    logic                        extra;
    logic signed [FIELD_W+2:0]   exw, exh;
    assign den = mag70(cr_reg[0]);
    always_comb
    begin
        extra = (cr_reg[0] == '0);
        for (int j = 1; j < 4; j++)
        begin
            if ((cr_reg[j] != '0) && (cr_reg[j][PROD_W-1] != cr_reg[0][PROD_W-1]))
                extra = 1'b1;
        end
        exw = 35'(tx_reg) - 35'(mx_reg[0]) + 35'(dw_reg[0]) + 35'sd1;
        exh = 35'(ty_reg) - 35'(my_reg[0]) + 35'(dh_reg[0]) + 35'sd1;
    end

    // restoring divider step
    logic [PROD_W-1:0] rs;
    logic              ge;
    assign rs = (step_reg == 5'd0) ? r_reg : (r_reg << 1);
    assign ge = (rs >= den);

    always_ff @(posedge clk)
    begin
        mul_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            entries_reg   <= CFG_W'(MIN_ENTRIES);
            out_valid_reg <= 1'b0;
            v_reg         <= '0;
            idx_reg       <= '0;
            step_reg      <= '0;
            wsel_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                entries_reg <= cfg_wdata;
            end
            if (rsp.valid && rsp.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (req.func == FUNC_QUERY))
                    begin
                        tx_reg    <= 33'(req.query_half_width) <<< 1;
                        ty_reg    <= 33'(req.query_half_height) <<< 1;
                        idx_reg   <= '0;
                        v_reg     <= '0;
                        state_reg <= S_MX;
                    end
                end
                S_MX:
                begin
                    state_reg <= S_MY;
                end
                S_MY:
                begin
                    acc_reg   <= mul_reg;
                    state_reg <= S_INS;
                end
                S_INS:
                begin
                    for (int j = 0; j < 3; j++)
                    begin
                        if (lt[j] && ((j == 0) || !lt[(j == 0) ? 0 : j-1]))
                        begin
                            bd_reg[j] <= cand_dist;
                            bi_reg[j] <= idx_reg;
                        end
                        else if (lt[j])
                        begin
                            bd_reg[j] <= bd_reg[(j == 0) ? 0 : j-1];
                            bi_reg[j] <= bi_reg[(j == 0) ? 0 : j-1];
                        end
                    end
                    // one more slot holds a candidate after each entry, until all three are filled
                    v_reg <= {v_reg[1:0], 1'b1};
                    if (idx_reg == last_idx)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_FETCH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_MX;
                    end
                end
                S_FETCH:
                begin
                    if (step_reg != 5'd0)
                    begin
                        for (int j = 0; j < 3; j++)
                        begin
                            if (step_reg == 5'(j + 1))
                            begin
                                mx_reg[j] <= signed'(mrd[FIELD_W-1:0]);
                                my_reg[j] <= signed'(mrd[2*FIELD_W-1:FIELD_W]);
                                dw_reg[j] <= signed'(drd[FIELD_W-1:0]);
                                dh_reg[j] <= signed'(drd[2*FIELD_W-1:FIELD_W]);
                            end
                        end
                    end
                    if (step_reg == 5'd3)
                    begin
                        step_reg  <= '0;
                        state_reg <= S_CROSS;
                    end
                    else
                    begin
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_CROSS:
                begin
                    // consume the product issued last cycle
                    if (step_reg != 5'd0)
                    begin
                        if (step_reg[0])
                            acc_reg <= mul_reg;
                        else
                            cr_reg[2'(step_reg[2:1] - 2'd1)] <= acc_reg - mul_reg;
                    end
                    if (step_reg == 5'd8)
                    begin
                        state_reg <= S_DECIDE;
                    end
                    step_reg <= step_reg + 5'd1;
                end
                S_DECIDE:
                begin
                    extra_reg <= extra;
                    if (extra)
                    begin
                        resw_reg  <= sat32(70'(exw >>> 1));
                        resh_reg  <= sat32(70'(exh >>> 1));
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        r_reg     <= mag70(cr_reg[1]);
                        q_reg     <= '0;
                        step_reg  <= '0;
                        wsel_reg  <= '0;
                        accw_reg  <= PROD_W'(1) <<< WEIGHT_BITS;
                        acch_reg  <= PROD_W'(1) <<< WEIGHT_BITS;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (step_reg == 5'(WEIGHT_BITS))
                    begin
                        w_reg[wsel_reg] <= {q_reg[WEIGHT_W-2:0], ge};
                        step_reg        <= '0;
                        if (wsel_reg == 2'd2)
                        begin
                            state_reg <= S_BLEND;
                        end
                        else
                        begin
                            r_reg    <= mag70(cr_reg[2'(wsel_reg + 2'd2)]);
                            q_reg    <= '0;
                            wsel_reg <= wsel_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        r_reg    <= ge ? (rs - den) : rs;
                        q_reg    <= {q_reg[WEIGHT_W-2:0], ge};
                        step_reg <= step_reg + 5'd1;
                    end
                end
                S_BLEND:
                begin
                    if (step_reg != 5'd0)
                    begin
                        if (step_reg[0])
                            accw_reg <= accw_reg + mul_reg;
                        else
                            acch_reg <= acch_reg + mul_reg;
                    end
                    if (step_reg == 5'd6)
                    begin
                        // last height product lands this cycle
                        resw_reg  <= sat32(accw_reg >>> (WEIGHT_BITS + 1));
                        resh_reg  <= sat32((acch_reg + mul_reg) >>> (WEIGHT_BITS + 1));
                        state_reg <= S_DONE;
                    end
                    step_reg <= step_reg + 5'd1;
                end
                S_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || rsp.ready)
                    begin
                        outw_reg      <= resw_reg;
                        outh_reg      <= resh_reg;
                        outx_reg      <= extra_reg;
                        outn_reg      <= INDEX_W'(bi_reg[0]);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid                 = out_valid_reg;
    assign rsp.corrected_half_width  = outw_reg;
    assign rsp.corrected_half_height = outh_reg;
    assign rsp.extrapolated          = outx_reg;
    assign rsp.nearest_entry         = outn_reg;

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg == 3'b000) || (v_reg == 3'b001) || (v_reg == 3'b011) || (v_reg == 3'b111))
        else $error("top-three valid bits not a prefix");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[1] && (state_reg != S_IDLE)) |-> !(bd_reg[1] < bd_reg[0]))
        else $error("top-three distances out of order");

    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_BLEND) && (step_reg == 5'd0)) |->
        ((33'(w_reg[0]) + 33'(w_reg[1]) + 33'(w_reg[2])) <= (33'(1) << WEIGHT_BITS)))
        else $error("barycentric weights sum above one");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.func == FUNC_LOAD)) |=> (state_reg == S_IDLE))
        else $error("load transaction left idle");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.func == FUNC_QUERY)) |=> !$rose(out_valid_reg))
        else $error("result raised straight after query");
endmodule

`default_nettype wire
